>>> sv/mbe_pkg.sv
package mbe_pkg;

  localparam int CW      = 64;
  localparam int FRAC    = CW - 7;
  localparam int ITER_W  = 16;
  localparam int CNT_W   = ITER_W + 1;
  localparam int PIX_W   = 12;
  localparam int DIM_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W    = 4;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NONE = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
  localparam logic [OP_W-1:0] OP_MDX  = 4'd2;
  localparam logic [OP_W-1:0] OP_MDY  = 4'd3;
  localparam logic [OP_W-1:0] OP_XS   = 4'd4;
  localparam logic [OP_W-1:0] OP_MY2  = 4'd5;
  localparam logic [OP_W-1:0] OP_MXS2 = 4'd6;
  localparam logic [OP_W-1:0] OP_QX   = 4'd7;
  localparam logic [OP_W-1:0] OP_MLHS = 4'd8;
  localparam logic [OP_W-1:0] OP_CARD = 4'd9;
  localparam logic [OP_W-1:0] OP_INC  = 4'd10;
  localparam logic [OP_W-1:0] OP_MZRR = 4'd11;
  localparam logic [OP_W-1:0] OP_MZII = 4'd12;
  localparam logic [OP_W-1:0] OP_MZRI = 4'd13;
  localparam logic [OP_W-1:0] OP_UPD  = 4'd14;
  localparam logic [OP_W-1:0] OP_OUT  = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            start;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic in_card;
    logic escaped;
    logic over;
  } sts_t;

  typedef struct packed {
    logic          start;
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic          neg;
    logic          offs;
  } mul_req_t;

  typedef struct packed {
    logic          done;
    logic [CW-1:0] res;
  } mul_rsp_t;

endpackage

>>> sv/mandelbrot_escape_time.sv
// mandelbrot escape-time unit: each pixel request (pixel_x_i, pixel_y_i) is mapped to
// c = focus + (2p - dim) * half_step in signed q6.57 and first tested against the main
// cardioid (in_cardioid_o = 1, count 0); otherwise z = z^2 + c is iterated until |re z|
// or |im z| exceeds 5 (count returned) or the count passes max_iterations (0 returned).
// one pixel is in flight at a time; every fixed-point product runs through one shared
// 32x32 multiplier in four partial-product steps, three products per iteration.
// the result sits in an output register, so the next request is taken while it waits.
// configuration is to be written through cfg_we_i / cfg_index_i / cfg_data_i only
// while idle; the user must keep to this, the block itself does not enforce it.
module mandelbrot_escape_time (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbe_pkg::CW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mbe_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [mbe_pkg::PIX_W-1:0]     pixel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mbe_pkg::CNT_W-1:0]     escape_count_o,
  output logic                          in_cardioid_o
);
  import mbe_pkg::*;

  // command from sequencer, status back from datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: cardioid pre-pass, then check / square / update loop
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: config registers, point and orbit registers, shared multiplier
  mbe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .escape_count_o (escape_count_o),
    .in_cardioid_o  (in_cardioid_o)
  );

endmodule

>>> sv/mbe_mul.sv
module mbe_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbe_pkg::mul_req_t req_i,
  output mbe_pkg::mul_rsp_t rsp_o
);
  import mbe_pkg::*;

  localparam logic [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int HW = CW / 2;

  logic [2:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   a_q, b_q, res_q, res_d;
  logic            neg_q, offs_q;
  logic [2*CW-1:0] acc_q, acc_d, pp_ext;
  logic [HW-1:0]   a_h, b_h;
  logic [CW-1:0]   pp, m;
  logic            ovf;

  // one 32x32 partial product per cycle
  always_comb begin
    a_h = cnt_q[0] ? a_q[CW-1:HW] : a_q[HW-1:0];
    b_h = cnt_q[1] ? b_q[CW-1:HW] : b_q[HW-1:0];
    pp  = a_h * b_h;
    case (cnt_q[1:0])
      2'b00:   pp_ext = {{CW{1'b0}}, pp};
      2'b11:   pp_ext = {pp, {CW{1'b0}}};
      default: pp_ext = {{HW{1'b0}}, pp, {HW{1'b0}}};
    endcase
  end

  // truncate magnitude, then sign and saturate
  always_comb begin
    if (offs_q) begin
      m   = acc_q[CW-1:0];
      ovf = |acc_q[2*CW-1:CW];
    end else begin
      m   = acc_q[FRAC+CW-1:FRAC];
      ovf = |acc_q[2*CW-1:FRAC+CW];
    end
    if (neg_q) begin
      res_d = (ovf || m[CW-1]) ? Q_MIN : (~m + 1'b1);
    end else begin
      res_d = (ovf || m[CW-1]) ? Q_MAX : m;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      acc_d  = '0;
    end else if (busy_q) begin
      if (cnt_q[2]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        acc_d = acc_q + pp_ext;
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 3'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (req_i.start && !busy_q) begin
      a_q    <= req_i.a;
      b_q    <= req_i.b;
      neg_q  <= req_i.neg;
      offs_q <= req_i.offs;
    end
    if (busy_q && cnt_q[2]) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

>>> sv/mbe_dp.sv
module mbe_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbe_pkg::CW-1:0]         cfg_data_i,
  input  logic [mbe_pkg::PIX_W-1:0]      pixel_x_i,
  input  logic [mbe_pkg::PIX_W-1:0]      pixel_y_i,
  input  mbe_pkg::cmd_t                  cmd_i,
  output mbe_pkg::sts_t                  sts_o,
  output logic [mbe_pkg::CNT_W-1:0]      escape_count_o,
  output logic                           in_cardioid_o
);
  import mbe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;

  localparam logic [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] BOUND_P = CW'(5) << FRAC;
  localparam logic signed [CW-1:0] BOUND_N = -BOUND_P;
  localparam logic signed [CW-1:0] TWO_P   = CW'(2) << FRAC;
  localparam logic signed [CW-1:0] TWO_N   = -TWO_P;
  localparam logic [CW-1:0] QUARTER = CW'(1) << (FRAC - 2);
  localparam int DX_W = DIM_W + 2;

  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) return s[CW] ? Q_MIN : Q_MAX;
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_sub(logic [CW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {a[CW-1], a} - {b[CW-1], b};
    if (s[CW] != s[CW-1]) return s[CW] ? Q_MIN : Q_MAX;
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mag(logic [CW-1:0] a);
    return a[CW-1] ? (~a + 1'b1) : a;
  endfunction

  // configuration
  logic [CW-1:0]     focus_re_q, focus_im_q;
  logic [CW-2:0]     half_q;
  logic [ITER_W-1:0] max_it_q;
  logic [DIM_W-1:0]  width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_re_q <= '0;
      focus_im_q <= '0;
      half_q     <= '0;
      max_it_q   <= ITER_W'(256);
      width_q    <= DIM_W'(640);
      height_q   <= DIM_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FOCUS_RE: focus_re_q <= cfg_data_i;
        REG_FOCUS_IM: focus_im_q <= cfg_data_i;
        REG_HALF:     half_q     <= cfg_data_i[CW-2:0];
        REG_MAX_IT:   max_it_q   <= cfg_data_i[ITER_W-1:0];
        REG_WIDTH:    width_q    <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:   height_q   <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic [DX_W-1:0]  dx_q, dy_q;
  logic [CW-1:0]    cr_q, ci_q, xs_q, y2_q, q_q, t_q, lhs_q;
  logic [CW-1:0]    zr_q, zi_q, nr_q, ni_q;
  logic             box_q, card_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] esc_cnt_q;
  logic             in_card_q;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic [CW-1:0] res;
  logic [CW-1:0] dxm, dym;

  assign res = mrsp.res;
  assign dxm = mag(CW'($signed(dx_q)));
  assign dym = mag(CW'($signed(dy_q)));

  always_comb begin
    mreq.start = cmd_i.start;
    mreq.offs  = 1'b0;
    mreq.a     = mag(zr_q);
    mreq.b     = mag(zr_q);
    mreq.neg   = 1'b0;
    case (cmd_i.op)
      OP_MDX: begin
        mreq.offs = 1'b1;
        mreq.a    = dxm;
        mreq.b    = {1'b0, half_q};
        mreq.neg  = dx_q[DX_W-1];
      end
      OP_MDY: begin
        mreq.offs = 1'b1;
        mreq.a    = dym;
        mreq.b    = {1'b0, half_q};
        mreq.neg  = dy_q[DX_W-1];
      end
      OP_MY2: begin
        mreq.a = mag(ci_q);
        mreq.b = mag(ci_q);
      end
      OP_MXS2: begin
        mreq.a = mag(xs_q);
        mreq.b = mag(xs_q);
      end
      OP_MLHS: begin
        mreq.a   = mag(q_q);
        mreq.b   = mag(t_q);
        mreq.neg = q_q[CW-1] ^ t_q[CW-1];
      end
      // re z squared uses the default operands
      OP_MZRR: ;
      OP_MZII: begin
        mreq.a = mag(zi_q);
        mreq.b = mag(zi_q);
      end
      OP_MZRI: begin
        mreq.a   = mag(zr_q);
        mreq.b   = mag(zi_q);
        mreq.neg = zr_q[CW-1] ^ zi_q[CW-1];
      end
      default: mreq.start = 1'b0;
    endcase
  end

  mbe_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        dx_q <= {2'b00, pixel_x_i, 1'b0} - {2'b00, width_q};
        dy_q <= {2'b00, pixel_y_i, 1'b0} - {2'b00, height_q};
      end
      OP_MDX: if (mrsp.done) cr_q <= sat_add(focus_re_q, res);
      OP_MDY: if (mrsp.done) ci_q <= sat_add(focus_im_q, res);
      OP_XS: begin
        xs_q  <= sat_sub(cr_q, QUARTER);
        box_q <= ($signed(cr_q) >= TWO_P) || ($signed(cr_q) <= TWO_N) ||
                 ($signed(ci_q) >= TWO_P) || ($signed(ci_q) <= TWO_N);
      end
      OP_MY2:  if (mrsp.done) y2_q <= res;
      OP_MXS2: if (mrsp.done) q_q <= sat_add(res, y2_q);
      OP_QX:   t_q <= sat_add(q_q, xs_q);
      OP_MLHS: if (mrsp.done) lhs_q <= res;
      OP_CARD: begin
        card_q  <= sts_o.in_card;
        zr_q    <= '0;
        zi_q    <= '0;
        count_q <= '0;
      end
      OP_INC:  count_q <= count_q + 1'b1;
      OP_MZRR: if (mrsp.done) t_q <= res;
      OP_MZII: if (mrsp.done) nr_q <= sat_sub(t_q, res);
      OP_MZRI: if (mrsp.done) ni_q <= sat_add(res, res);
      OP_UPD: begin
        zr_q <= sat_add(nr_q, cr_q);
        zi_q <= sat_add(ni_q, ci_q);
      end
      OP_OUT: begin
        esc_cnt_q <= (!card_q && sts_o.escaped) ? count_q : '0;
        in_card_q <= card_q;
      end
      default: ;
    endcase
  end

  assign sts_o.mul_done = mrsp.done;
  assign sts_o.in_card  = !box_q && ($signed(lhs_q) < ($signed(y2_q) >>> 2));
  assign sts_o.escaped  = ($signed(zr_q) > BOUND_P) || ($signed(zr_q) < BOUND_N) ||
                          ($signed(zi_q) > BOUND_P) || ($signed(zi_q) < BOUND_N);
  assign sts_o.over     = count_q > {1'b0, max_it_q};

  assign escape_count_o = esc_cnt_q;
  assign in_cardioid_o  = in_card_q;

endmodule

>>> sv/mbe_ctrl.sv
module mbe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  mbe_pkg::sts_t sts_i,
  output mbe_pkg::cmd_t cmd_o
);
  import mbe_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MDX  = 4'd1;
  localparam logic [3:0] S_MDY  = 4'd2;
  localparam logic [3:0] S_XS   = 4'd3;
  localparam logic [3:0] S_MY2  = 4'd4;
  localparam logic [3:0] S_MXS2 = 4'd5;
  localparam logic [3:0] S_QX   = 4'd6;
  localparam logic [3:0] S_MLHS = 4'd7;
  localparam logic [3:0] S_CARD = 4'd8;
  localparam logic [3:0] S_INC  = 4'd9;
  localparam logic [3:0] S_EVAL = 4'd10;
  localparam logic [3:0] S_MZRR = 4'd11;
  localparam logic [3:0] S_MZII = 4'd12;
  localparam logic [3:0] S_MZRI = 4'd13;
  localparam logic [3:0] S_UPD  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0] state_q, state_d;
  logic       first_q;
  logic       ovalid_q, ovalid_d;
  logic [OP_W-1:0] op;

  always_comb begin
    state_d  = state_q;
    op       = OP_NONE;
    ovalid_d = ovalid_q && !out_ready_i;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        op      = OP_LOAD;
        state_d = S_MDX;
      end
      S_MDX: begin
        op = OP_MDX;
        if (sts_i.mul_done) state_d = S_MDY;
      end
      S_MDY: begin
        op = OP_MDY;
        if (sts_i.mul_done) state_d = S_XS;
      end
      S_XS: begin
        op      = OP_XS;
        state_d = S_MY2;
      end
      S_MY2: begin
        op = OP_MY2;
        if (sts_i.mul_done) state_d = S_MXS2;
      end
      S_MXS2: begin
        op = OP_MXS2;
        if (sts_i.mul_done) state_d = S_QX;
      end
      S_QX: begin
        op      = OP_QX;
        state_d = S_MLHS;
      end
      S_MLHS: begin
        op = OP_MLHS;
        if (sts_i.mul_done) state_d = S_CARD;
      end
      S_CARD: begin
        op      = OP_CARD;
        state_d = sts_i.in_card ? S_DONE : S_INC;
      end
      S_INC: begin
        op      = OP_INC;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = (sts_i.escaped || sts_i.over) ? S_DONE : S_MZRR;
      end
      S_MZRR: begin
        op = OP_MZRR;
        if (sts_i.mul_done) state_d = S_MZII;
      end
      S_MZII: begin
        op = OP_MZII;
        if (sts_i.mul_done) state_d = S_MZRI;
      end
      S_MZRI: begin
        op = OP_MZRI;
        if (sts_i.mul_done) state_d = S_UPD;
      end
      S_UPD: begin
        op      = OP_UPD;
        state_d = S_INC;
      end
      S_DONE: if (!ovalid_q || out_ready_i) begin
        op       = OP_OUT;
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      first_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      first_q  <= state_d != state_q;
      ovalid_q <= ovalid_d;
    end
  end

  assign cmd_o.op    = op;
  assign cmd_o.start = first_q;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ovalid_q;

endmodule

>>> sv/mbe_checker.sv
module mbe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mbe_pkg::CNT_W-1:0]     escape_count_o,
  input logic                          in_cardioid_o
);
  import mbe_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(escape_count_o) && $stable(in_cardioid_o))
    else $error("result changed while stalled");

  a_card_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_cardioid_o |-> escape_count_o == '0)
    else $error("cardioid point with non-zero count");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> escape_count_o <= CNT_W'(65536))
    else $error("count out of range");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

>>> tb/sv/mbe_checker.sv
module mbe_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbe_pkg::CW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [mbe_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [mbe_pkg::PIX_W-1:0]     pixel_y_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mbe_pkg::CNT_W-1:0]     escape_count_i,
  input  logic                          in_cardioid_i,
  output int                            failures_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  typedef enum int {
    REG_FOCUS_RE, REG_FOCUS_IM, REG_HALF_STEP, REG_MAX_ITER, REG_WIDTH, REG_HEIGHT
  } reg_idx_e;

  typedef logic signed [CW-1:0] q_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             card;
  } pixel_res_t;

  localparam q_t Q_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam q_t Q_ONE = q_t'(1) <<< FRAC;

  q_t               focus_re, focus_im;
  logic [CW-2:0]    half_step;
  logic [ITER_W-1:0] max_iter;
  logic [DIM_W-1:0] img_w, img_h;
  pixel_res_t       expected_q[$];
  int               fails;

  assign failures_o = fails;
  assign pending_o  = expected_q.size();

  function automatic logic [CW-1:0] magnitude(q_t a);
    return a[CW-1] ? -a : a;
  endfunction

  function automatic q_t apply_sign(logic [CW-1:0] m, logic neg, logic ovf);
    if (neg) begin
      if (ovf || m >= {1'b1, {(CW-1){1'b0}}}) return Q_MIN;
      return -q_t'(m);
    end
    if (ovf || m > Q_MAX) return Q_MAX;
    return q_t'(m);
  endfunction

  function automatic q_t sat_sum(q_t a, q_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s > $signed({1'b0, Q_MAX})) return Q_MAX;
    if (s < $signed({1'b1, Q_MIN})) return Q_MIN;
    return q_t'(s);
  endfunction

  function automatic q_t fx_mul(q_t a, q_t b);
    logic [2*CW-1:0] p;
    p = magnitude(a) * magnitude(b);
    if (p[2*CW-1:CW+FRAC] != '0) return apply_sign('0, a[CW-1] ^ b[CW-1], 1'b1);
    return apply_sign(p[CW+FRAC-1:FRAC], a[CW-1] ^ b[CW-1], 1'b0);
  endfunction

  function automatic q_t offset_scale(q_t k, logic [CW-2:0] step);
    logic [2*CW-1:0] p;
    p = magnitude(k) * {1'b0, step};
    return apply_sign(p[CW-1:0], k[CW-1], p[2*CW-1:CW] != '0);
  endfunction

  function automatic logic inside_cardioid(q_t cr, q_t ci);
    q_t two, xs, y2, qq, lhs;
    two = Q_ONE <<< 1;
    if (cr >= two || cr <= -two || ci >= two || ci <= -two) return 1'b0;
    xs  = sat_sum(cr, -(Q_ONE >>> 2));
    y2  = fx_mul(ci, ci);
    qq  = sat_sum(fx_mul(xs, xs), y2);
    lhs = fx_mul(qq, sat_sum(qq, xs));
    return lhs < (y2 >>> 2);
  endfunction

  function automatic pixel_res_t escape_time(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    q_t dx, dy, cr, ci, zr, zi, nr, ni, bound;
    int unsigned cnt;
    logic esc;
    pixel_res_t r;
    dx = 2 * q_t'(px) - q_t'(img_w);
    dy = 2 * q_t'(py) - q_t'(img_h);
    cr = sat_sum(focus_re, offset_scale(dx, half_step));
    ci = sat_sum(focus_im, offset_scale(dy, half_step));
    bound = 5 * Q_ONE;
    r.count = '0;
    r.card  = 1'b0;
    if (inside_cardioid(cr, ci)) begin
      r.card = 1'b1;
      return r;
    end
    zr = '0;
    zi = '0;
    cnt = 0;
    esc = 1'b0;
    forever begin
      if (zr > bound || zr < -bound || zi > bound || zi < -bound) esc = 1'b1;
      cnt++;
      if (esc || cnt > max_iter) break;
      nr = sat_sum(fx_mul(zr, zr), -fx_mul(zi, zi));
      ni = fx_mul(zr, zi);
      ni = sat_sum(ni, ni);
      zr = sat_sum(nr, cr);
      zi = sat_sum(ni, ci);
    end
    if (esc) r.count = CNT_W'(cnt);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_res_t e;
    if (!rst_ni) begin
      focus_re  <= '0;
      focus_im  <= '0;
      half_step <= '0;
      max_iter  <= 16'd256;
      img_w     <= 13'd640;
      img_h     <= 13'd480;
      fails     <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (int'(cfg_index_i))
          REG_FOCUS_RE:  focus_re  <= q_t'(cfg_data_i);
          REG_FOCUS_IM:  focus_im  <= q_t'(cfg_data_i);
          REG_HALF_STEP: half_step <= cfg_data_i[CW-2:0];
          REG_MAX_ITER:  max_iter  <= cfg_data_i[ITER_W-1:0];
          REG_WIDTH:     img_w     <= cfg_data_i[DIM_W-1:0];
          REG_HEIGHT:    img_h     <= cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(escape_time(pixel_x_i, pixel_y_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("unexpected result count=%0d card=%0b",
                                   escape_count_i, in_cardioid_i);
          fails <= fails + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.count !== escape_count_i || e.card !== in_cardioid_i) begin
            if (fails < 10) $display("result mismatch: exp count=%0d card=%0b got count=%0d card=%0b",
                                     e.count, e.card, escape_count_i, in_cardioid_i);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  // register indexes as the block decodes them
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_FOCUS_RE  = 3'd0,
    IDX_FOCUS_IM  = 3'd1,
    IDX_HALF_STEP = 3'd2,
    IDX_MAX_ITER  = 3'd3,
    IDX_WIDTH     = 3'd4,
    IDX_HEIGHT    = 3'd5
  } cfg_idx_e;

  localparam logic [CW-1:0] ONE_Q = 64'd1 << FRAC;

  logic             clk, rst_n;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]    cfg_data;
  logic             in_valid, in_ready;
  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic             out_valid, out_ready;
  logic [CNT_W-1:0] escape_count;
  logic             in_cardioid;
  int               failures, pending;
  int               req_gap_max, rsp_gap_max;

  mandelbrot_escape_time uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pixel_x_i(pixel_x), .pixel_y_i(pixel_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .escape_count_o(escape_count), .in_cardioid_o(in_cardioid)
  );

  mbe_scoreboard u_scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .pixel_x_i(pixel_x), .pixel_y_i(pixel_y),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .escape_count_i(escape_count), .in_cardioid_i(in_cardioid),
    .failures_o(failures), .pending_o(pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // hard stop in case the block hangs
  initial begin
    #400ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one register write, one cycle of write enable
  task automatic write_reg(cfg_idx_e idx, logic [CW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(logic [CW-1:0] fre, logic [CW-1:0] fim, logic [CW-1:0] hs,
                           logic [CW-1:0] iters, logic [CW-1:0] w, logic [CW-1:0] h);
    write_reg(IDX_FOCUS_RE, fre);
    write_reg(IDX_FOCUS_IM, fim);
    write_reg(IDX_HALF_STEP, hs);
    write_reg(IDX_MAX_ITER, iters);
    write_reg(IDX_WIDTH, w);
    write_reg(IDX_HEIGHT, h);
  endtask

  // one pixel request; valid stays high across back-to-back requests
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= px;
    pixel_y  <= py;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and let every outstanding result drain before touching registers
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // result side: a random stall before each result, then ready until it is taken
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = $urandom_range(0, rsp_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int w, h, n_items;
    logic [CW-1:0] hs, fre, fim;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    pixel_x     <= '0;
    pixel_y     <= '0;
    req_gap_max = 17;
    rsp_gap_max = 17;
    rst_n       <= 1'b0;
    repeat (4) @(negedge clk);
    rst_n       <= 1'b1;
    @(negedge clk);

    // reset settings: half step zero puts every pixel on c = 0, inside the cardioid
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd320, 12'd240);
    drain();

    // extreme focus and step, largest limit: offsets saturate or are zero, and every pixel escapes at once
    write_all({1'b0, {63{1'b1}}}, {1'b1, {63{1'b0}}}, {64{1'b1}}, 64'hffff, 64'd4096, 64'd2);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'd1);
    send_pixel(12'd2048, 12'd1);
    send_pixel(12'd2048, 12'd0);
    drain();

    // limit of zero: centre pixel still caught by the cardioid test, the rest give 0
    write_all(64'd0, 64'd0, {64{1'b1}}, 64'd0, 64'd2, 64'd2);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'hfff);
    drain();
    // wide register values are cut to the register width
    write_reg(IDX_WIDTH, {64{1'b1}});
    write_reg(IDX_MAX_ITER, 64'hffff_0003);
    send_pixel(12'hfff, 12'd1);
    send_pixel(12'h555, 12'haaa);
    drain();

    // c exactly on the edge of the cardioid bounding box, both sides
    write_all(2 * ONE_Q, 64'd0, 64'd0, 64'd4, 64'd8, 64'd8);
    send_pixel(12'd3, 12'd7);
    drain();
    write_reg(IDX_FOCUS_RE, -(2 * ONE_Q));
    send_pixel(12'd3, 12'd7);
    drain();
    write_reg(IDX_FOCUS_RE, 64'd0);
    write_reg(IDX_FOCUS_IM, 2 * ONE_Q);
    send_pixel(12'd0, 12'd0);
    drain();

    // classic view, small image, a few pixels including out of image
    write_all(-(ONE_Q >> 1), 64'd0, (3 * ONE_Q) / 32, 64'd20, 64'd16, 64'd16);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd8, 12'd8);
    send_pixel(12'd15, 12'd15);
    send_pixel(12'd4, 12'd9);
    send_pixel(12'hfff, 12'd0);
    drain();

    // random phases: view around the set or fully random, mostly in-image pixels, some stray ones
    for (int ph = 0; ph < 13; ph++) begin
      case ($urandom_range(0, 3))
        0: w = $urandom_range(2, 64);
        1: w = $urandom_range(2, 4096);
        2: w = 4096;
        default: w = $urandom_range(100, 800);
      endcase
      h = (ph % 4 == 0) ? 4096 : $urandom_range(2, 4096);
      hs  = (3 * ONE_Q) / (2 * w);
      if ($urandom_range(0, 3) == 0) hs = hs >> $urandom_range(1, 8);
      fre = -(ONE_Q >> 1) + $signed({{33{1'b0}}, $urandom}) * 64'sd30000000
            - (ONE_Q >> 1);
      fim = $signed({{33{1'b0}}, $urandom}) * 64'sd20000000 - ONE_Q;
      if (ph % 5 == 4) begin
        fre = {$urandom, $urandom};
        fim = {$urandom, $urandom};
        hs  = {$urandom, $urandom};
      end
      // some phases run without any idling on either side
      req_gap_max = (ph % 3 == 1) ? 0 : 17;
      rsp_gap_max = (ph % 4 == 2) ? 0 : 17;
      write_all(fre, fim, hs, CW'($urandom_range(1, 24)), CW'(w), CW'(h));
      n_items = 95;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
        else
          send_pixel(PIX_W'($urandom_range(0, w - 1)), PIX_W'($urandom_range(0, h - 1)));
      end
      drain();
    end

    repeat (100) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
